// ===== rtl/bce_pkg.sv =====
// Shared types and constants of the battery capacity estimator.
// Holds the two discharge/charge curves with their slopes and the cell-row types.
// No dependencies.
package bce_pkg;

	localparam int VOLT_W       = 13;
	localparam int CAP_W        = 7;
	localparam int ST_W         = 2;
	localparam int CURVE_POINTS = 8;
	localparam int SEG_W        = $clog2(CURVE_POINTS - 1);
	localparam int K_W          = 16;
	localparam int FRAC_W       = 16;

	localparam logic [ST_W-1:0] ST_DIS  = 2'd0;
	localparam logic [ST_W-1:0] ST_CHG  = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;
	localparam logic [ST_W-1:0] ST_ALT  = 2'd3;

	localparam logic [CAP_W-1:0] CAP_FULL    = 7'd100;
	localparam logic [CAP_W-1:0] CAP_TOP_CHG = 7'd99;
	localparam logic [CAP_W-1:0] CAP_SNAP    = 7'd95;

	localparam logic [VOLT_W-1:0] DIS_V [CURVE_POINTS] = '{
		13'd3600, 13'd3648, 13'd3680, 13'd3744, 13'd3855, 13'd3916, 13'd4060, 13'd4200};
	localparam logic [CAP_W-1:0] DIS_C [CURVE_POINTS] = '{
		7'd0, 7'd10, 7'd20, 7'd40, 7'd60, 7'd80, 7'd90, 7'd100};
	localparam logic [VOLT_W-1:0] CHG_V [CURVE_POINTS] = '{
		13'd3690, 13'd3744, 13'd3776, 13'd3828, 13'd3936, 13'd4060, 13'd4140, 13'd4230};
	localparam logic [CAP_W-1:0] CHG_C [CURVE_POINTS] = '{
		7'd0, 7'd10, 7'd20, 7'd40, 7'd60, 7'd80, 7'd90, 7'd100};

	// slope of each segment in 0.16, truncated
	localparam logic [K_W-1:0] DIS_K [CURVE_POINTS-1] = '{
		16'((10 * 65536) / 48),
		16'((10 * 65536) / 32),
		16'((20 * 65536) / 64),
		16'((20 * 65536) / 111),
		16'((20 * 65536) / 61),
		16'((10 * 65536) / 144),
		16'((10 * 65536) / 140)};
	localparam logic [K_W-1:0] CHG_K [CURVE_POINTS-1] = '{
		16'((10 * 65536) / 54),
		16'((10 * 65536) / 32),
		16'((20 * 65536) / 52),
		16'((20 * 65536) / 108),
		16'((20 * 65536) / 124),
		16'((10 * 65536) / 80),
		16'((10 * 65536) / 90)};

	typedef enum logic [1:0] {
		KIND_ZERO = 2'd0,
		KIND_LERP = 2'd1,
		KIND_FULL = 2'd2
	} curve_kind_t;

	typedef struct packed {
		logic [CAP_W-1:0]  cap;
		logic [VOLT_W-1:0] volt;
	} cell_ent_t;

	typedef struct packed {
		logic swap_up;
		logic swap_dn;
	} cell_mv_t;

endpackage

// ===== rtl/bce_curve.sv =====
// Voltage to percent mapping through the piecewise-linear curves, three stages.
// Depends on bce_pkg for the curve tables and widths.
module bce_curve (
	input  logic                       clk,
	input  logic [bce_pkg::VOLT_W-1:0] volt,
	input  logic [bce_pkg::ST_W-1:0]   state,
	output logic [bce_pkg::CAP_W-1:0]  cap
);
	import bce_pkg::*;

	localparam int PROD_W = VOLT_W + K_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int C_W    = ACC_W - FRAC_W;

	logic [VOLT_W-1:0] dv_d;
	logic [K_W-1:0]    k_d;
	logic [CAP_W-1:0]  c1_d;
	curve_kind_t       kind_d;

	logic [VOLT_W-1:0] dv_s1;
	logic [K_W-1:0]    k_s1;
	logic [CAP_W-1:0]  c1_s1;
	curve_kind_t       kind_s1;

	logic [PROD_W-1:0] prod_s2;
	logic [CAP_W-1:0]  c1_s2;
	curve_kind_t       kind_s2;

	logic [ACC_W-1:0]  acc;
	logic [C_W-1:0]    c_int;

	always_comb begin
		logic              chg;
		logic              found;
		logic [SEG_W-1:0]  seg;
		logic [VOLT_W-1:0] v1;
		chg   = (state != ST_DIS);
		found = 1'b0;
		seg   = '0;
		for (int i = 0; i < CURVE_POINTS - 1; i++) begin
			if (!found && volt <= (chg ? CHG_V[i+1] : DIS_V[i+1])) begin
				found = 1'b1;
				seg   = SEG_W'(i);
			end
		end
		v1   = chg ? CHG_V[seg] : DIS_V[seg];
		dv_d = volt - v1;
		k_d  = chg ? CHG_K[seg] : DIS_K[seg];
		c1_d = chg ? CHG_C[seg] : DIS_C[seg];
		if (state != ST_DIS && state != ST_CHG) begin
			kind_d = KIND_FULL;
		end else if (volt <= (chg ? CHG_V[0] : DIS_V[0])) begin
			kind_d = KIND_ZERO;
		end else if (!found) begin
			kind_d = KIND_FULL;
		end else begin
			kind_d = KIND_LERP;
		end
	end

	always_ff @(posedge clk) begin
		dv_s1   <= dv_d;
		k_s1    <= k_d;
		c1_s1   <= c1_d;
		kind_s1 <= kind_d;
		prod_s2 <= PROD_W'(dv_s1) * PROD_W'(k_s1);
		c1_s2   <= c1_s1;
		kind_s2 <= kind_s1;
	end

	assign acc   = {1'b0, prod_s2} + (ACC_W'(c1_s2) << FRAC_W);
	assign c_int = acc[ACC_W-1:FRAC_W];

	always_comb begin
		case (kind_s2)
			KIND_ZERO: cap = '0;
			KIND_LERP: cap = (c_int > C_W'(CAP_FULL)) ? CAP_FULL : c_int[CAP_W-1:0];
			default:   cap = CAP_FULL;
		endcase
	end

endmodule

// ===== rtl/bce_cell.sv =====
// One position of the sorted sample row: entry, slot tag, insertion mark, partial sum.
// Swaps with a neighbor to settle a new entry; passes a running sum downward.
// Depends on bce_pkg for the entry and move types.
module bce_cell #(
	parameter int TAG_W = 4,
	parameter int SUM_W = 11,
	parameter int IDX   = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ld,
	input  logic [TAG_W-1:0]    slot,
	input  bce_pkg::cell_ent_t  ld_ent,
	input  logic                sort_en,
	input  logic                sel,
	input  logic                has_up,
	input  logic                has_dn,
	input  bce_pkg::cell_ent_t  up_ent,
	input  logic [TAG_W-1:0]    up_tag,
	input  bce_pkg::cell_mv_t   up_mv,
	input  logic [SUM_W-1:0]    up_psum,
	input  bce_pkg::cell_ent_t  dn_ent,
	input  logic [TAG_W-1:0]    dn_tag,
	input  bce_pkg::cell_mv_t   dn_mv,
	output bce_pkg::cell_ent_t  ent,
	output logic [TAG_W-1:0]    tag,
	output bce_pkg::cell_mv_t   mv,
	output logic [SUM_W-1:0]    psum
);
	import bce_pkg::*;

	cell_ent_t        ent_q;
	logic [TAG_W-1:0] tag_q;
	logic             mark_q;
	logic [SUM_W-1:0] psum_q;
	logic             swap_up;
	logic             swap_dn;

	function automatic logic gt(cell_ent_t a, cell_ent_t b);
		return (a.cap > b.cap) || (a.cap == b.cap && a.volt > b.volt);
	endfunction

	assign swap_up = sort_en && mark_q && has_up && !gt(up_ent, ent_q);
	assign swap_dn = sort_en && mark_q && has_dn && gt(dn_ent, ent_q) && !swap_up;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q  <= '0;
			tag_q  <= TAG_W'(IDX);
			mark_q <= 1'b0;
		end else if (ld) begin
			if (tag_q == slot) begin
				ent_q  <= ld_ent;
				mark_q <= 1'b1;
			end else begin
				mark_q <= 1'b0;
			end
		end else if (swap_up) begin
			ent_q  <= up_ent;
			tag_q  <= up_tag;
			mark_q <= 1'b0;
		end else if (swap_dn) begin
			ent_q  <= dn_ent;
			tag_q  <= dn_tag;
			mark_q <= 1'b0;
		end else if (up_mv.swap_dn) begin
			ent_q  <= up_ent;
			tag_q  <= up_tag;
			mark_q <= 1'b1;
		end else if (dn_mv.swap_up) begin
			ent_q  <= dn_ent;
			tag_q  <= dn_tag;
			mark_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		psum_q <= up_psum + (sel ? SUM_W'(ent_q.cap) : SUM_W'(0));
	end

	assign ent        = ent_q;
	assign tag        = tag_q;
	assign mv.swap_up = swap_up;
	assign mv.swap_dn = swap_dn;
	assign psum       = psum_q;

endmodule

// ===== rtl/battery_capacity_estimator.sv =====
// Top level of the voltage-based battery fuel gauge: control, cell row, mean, output beat.
// Depends on bce_pkg, bce_curve and bce_cell.
//
// Each accepted poll beat yields exactly one result beat. A poll whose charge state
// differs from the last one only records the state, restarts any fill in progress
// and reports. Any other poll passes through the curve pipeline (S_SEG, S_MUL,
// S_CAP), then through the row of WINDOW cells (S_RUN), where the new sample swaps
// with one neighbor per cycle into its sorted place (at most WINDOW-1 swaps) and the
// trimmed sum then ripples down the row one cell per cycle, then the reciprocal
// multiply that replaces the division (S_DIV), the capacity update (S_FIN), the load
// of the output register (S_WB) and the return to idle to take the next poll.
// A stalled result beat holds the block in S_WB until it leaves.
// The output register holds a result while the next poll is taken.
module battery_capacity_estimator #(
	parameter int WINDOW = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       poll_valid,
	output logic                       poll_stall,
	input  logic [bce_pkg::VOLT_W-1:0] voltage_mv,
	input  logic [bce_pkg::ST_W-1:0]   charge_state,
	input  logic                       restart,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [bce_pkg::CAP_W-1:0]  capacity,
	output logic                       report,
	output logic                       filling
);
	import bce_pkg::*;

	localparam int TAG_W    = $clog2(WINDOW);
	localparam int FILL_W   = $clog2(WINDOW + 1);
	localparam int SUM_W    = CAP_W + $clog2(WINDOW);
	localparam int RUN_CYC  = 2 * WINDOW - 1;
	localparam int RUN_W    = $clog2(RUN_CYC);
	localparam int CNT_CHG0 = WINDOW - 4;
	localparam int CNT_DIS0 = WINDOW - (WINDOW / 2 + 1);
	localparam int CNT_CHG  = (CNT_CHG0 < 1) ? 1 : CNT_CHG0;
	localparam int CNT_DIS  = (CNT_DIS0 < 1) ? 1 : CNT_DIS0;
	localparam int HALF_CHG = CNT_CHG / 2;
	localparam int HALF_DIS = CNT_DIS / 2;
	localparam int DIV_S    = SUM_W + 4;
	localparam int M_W      = DIV_S + 1;
	localparam int M_CHG    = ((1 << DIV_S) + CNT_CHG - 1) / CNT_CHG;
	localparam int M_DIS    = ((1 << DIV_S) + CNT_DIS - 1) / CNT_DIS;
	localparam int PROD_W   = SUM_W + M_W;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SEG  = 8'b0000_0010,
		S_MUL  = 8'b0000_0100,
		S_CAP  = 8'b0000_1000,
		S_RUN  = 8'b0001_0000,
		S_DIV  = 8'b0010_0000,
		S_FIN  = 8'b0100_0000,
		S_WB   = 8'b1000_0000
	} fsm_t;

	fsm_t              state_q;
	logic [FILL_W-1:0] fill_q;
	logic [ST_W-1:0]   last_q;
	logic [CAP_W-1:0]  rep_q;
	logic [TAG_W-1:0]  slot_q;
	logic              res_valid_q;

	logic [VOLT_W-1:0] volt_q;
	logic [ST_W-1:0]   st_q;
	logic              rpt_q;
	logic              fend_q;
	logic              need_q;
	logic [RUN_W-1:0]  run_q;
	logic [PROD_W-1:0] mul_s1;
	logic [CAP_W-1:0]  capacity_q;
	logic              report_q;
	logic              filling_q;

	logic              poll_fire;
	logic              wb_fire;
	logic              chg;
	logic [ST_W-1:0]   st_in;
	logic [FILL_W-1:0] fill_in;
	logic [CAP_W-1:0]  cap_raw;
	logic [CAP_W-1:0]  cap_hold;
	logic [FILL_W-1:0] fill_nx;
	logic              fend_nx;
	logic [TAG_W-1:0]  slot_nx;
	logic [SUM_W-1:0]  num;
	logic [M_W-1:0]    m_sel;
	logic [PROD_W-1:0] prod_d;
	logic [CAP_W-1:0]  avg;
	logic [CAP_W-1:0]  avg1;
	logic [CAP_W-1:0]  rep_nx;
	logic              rpt_up;
	cell_ent_t         ld_ent;

	cell_ent_t         ent_w  [WINDOW];
	logic [TAG_W-1:0]  tag_w  [WINDOW];
	cell_mv_t          mv_w   [WINDOW];
	logic [SUM_W-1:0]  psum_w [WINDOW];

	assign poll_stall = (state_q != S_IDLE);
	assign poll_fire  = poll_valid && !poll_stall;
	assign wb_fire    = (state_q == S_WB) && (!res_valid_q || !result_stall);
	assign chg        = (st_q != ST_DIS);

	assign st_in   = (charge_state == ST_ALT) ? ST_FULL : charge_state;
	assign fill_in = restart ? FILL_W'(1) : fill_q;

	bce_curve u_curve (
		.clk   (clk),
		.volt  (volt_q),
		.state (st_q),
		.cap   (cap_raw)
	);

	// hold against movement in the wrong direction once filled
	always_comb begin
		if (fill_q != '0) begin
			cap_hold = cap_raw;
		end else if (chg) begin
			cap_hold = (cap_raw > rep_q) ? cap_raw : rep_q;
		end else begin
			cap_hold = (cap_raw < rep_q) ? cap_raw : rep_q;
		end
	end

	always_comb begin
		fill_nx = fill_q;
		fend_nx = 1'b0;
		if (fill_q != '0) begin
			if (fill_q >= FILL_W'(WINDOW)) begin
				fill_nx = '0;
				fend_nx = 1'b1;
			end else begin
				fill_nx = fill_q + 1'b1;
			end
		end
	end

	assign slot_nx     = (slot_q == TAG_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
	assign ld_ent.cap  = cap_hold;
	assign ld_ent.volt = volt_q;

	generate
		for (genvar i = 0; i < WINDOW; i++) begin : g_cell
			localparam bit SEL_C = (i >= 2) && (i < 2 + CNT_CHG);
			localparam bit SEL_D = (i >= 1) && (i < 1 + CNT_DIS);
			cell_ent_t        up_ent;
			logic [TAG_W-1:0] up_tag;
			cell_mv_t         up_mv;
			logic [SUM_W-1:0] up_psum;
			cell_ent_t        dn_ent;
			logic [TAG_W-1:0] dn_tag;
			cell_mv_t         dn_mv;
			logic             has_up;
			logic             has_dn;

			if (i == 0) begin : g_first
				assign up_ent  = '0;
				assign up_tag  = '0;
				assign up_mv   = '0;
				assign up_psum = '0;
				assign has_up  = 1'b0;
			end else begin : g_up
				assign up_ent  = ent_w[i-1];
				assign up_tag  = tag_w[i-1];
				assign up_mv   = mv_w[i-1];
				assign up_psum = psum_w[i-1];
				assign has_up  = 1'b1;
			end

			if (i == WINDOW - 1) begin : g_last
				assign dn_ent = '0;
				assign dn_tag = '0;
				assign dn_mv  = '0;
				assign has_dn = 1'b0;
			end else begin : g_dn
				assign dn_ent = ent_w[i+1];
				assign dn_tag = tag_w[i+1];
				assign dn_mv  = mv_w[i+1];
				assign has_dn = 1'b1;
			end

			bce_cell #(
				.TAG_W (TAG_W),
				.SUM_W (SUM_W),
				.IDX   (i)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ld      (state_q == S_CAP),
				.slot    (slot_q),
				.ld_ent  (ld_ent),
				.sort_en (state_q == S_RUN),
				.sel     (chg ? SEL_C : SEL_D),
				.has_up  (has_up),
				.has_dn  (has_dn),
				.up_ent  (up_ent),
				.up_tag  (up_tag),
				.up_mv   (up_mv),
				.up_psum (up_psum),
				.dn_ent  (dn_ent),
				.dn_tag  (dn_tag),
				.dn_mv   (dn_mv),
				.ent     (ent_w[i]),
				.tag     (tag_w[i]),
				.mv      (mv_w[i]),
				.psum    (psum_w[i])
			);
		end
	endgenerate

	// rounded mean by multiplying with the reciprocal of the sample count
	assign num    = psum_w[WINDOW-1] + (chg ? SUM_W'(HALF_CHG) : SUM_W'(HALF_DIS));
	assign m_sel  = chg ? M_W'(M_CHG) : M_W'(M_DIS);
	assign prod_d = PROD_W'(num) * PROD_W'(m_sel);
	assign avg    = mul_s1[DIV_S +: CAP_W];
	assign avg1   = (avg == CAP_FULL && st_q == ST_CHG) ? CAP_TOP_CHG : avg;

	always_comb begin
		rep_nx = rep_q;
		rpt_up = 1'b0;
		if (need_q && avg1 != rep_q) begin
			if (!fend_q) begin
				if (chg == (avg1 > rep_q)) begin
					rep_nx = chg ? rep_q + 1'b1 : rep_q - 1'b1;
					rpt_up = 1'b1;
				end
			end else if (chg && avg1 >= CAP_SNAP && avg1 < CAP_FULL) begin
				rep_nx = CAP_FULL;
			end else begin
				rep_nx = avg1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= FILL_W'(1);
			last_q      <= ST_DIS;
			rep_q       <= CAP_FULL;
			slot_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (wb_fire) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (poll_fire) begin
						if (st_in != last_q) begin
							last_q  <= st_in;
							fill_q  <= (fill_in != '0) ? FILL_W'(1) : '0;
							state_q <= S_WB;
						end else begin
							fill_q  <= fill_in;
							state_q <= S_SEG;
						end
					end
				end
				S_SEG: state_q <= S_MUL;
				S_MUL: state_q <= S_CAP;
				S_CAP: begin
					fill_q  <= fill_nx;
					slot_q  <= slot_nx;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (run_q == '0) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: state_q <= S_FIN;
				S_FIN: begin
					rep_q   <= rep_nx;
					state_q <= S_WB;
				end
				S_WB: begin
					if (wb_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (poll_fire) begin
			volt_q <= voltage_mv;
			st_q   <= st_in;
			rpt_q  <= (st_in != last_q);
		end
		if (state_q == S_CAP) begin
			fend_q <= fend_nx;
			rpt_q  <= fend_nx;
			need_q <= (fill_nx == '0) && (cap_hold != rep_q);
			run_q  <= RUN_W'(RUN_CYC - 1);
		end else if (state_q == S_RUN) begin
			run_q <= run_q - 1'b1;
		end
		if (state_q == S_DIV) begin
			mul_s1 <= prod_d;
		end
		if (state_q == S_FIN && rpt_up) begin
			rpt_q <= 1'b1;
		end
		if (wb_fire) begin
			capacity_q <= rep_q;
			report_q   <= rpt_q;
			filling_q  <= (fill_q != '0);
		end
	end

	assign result_valid = res_valid_q;
	assign capacity     = capacity_q;
	assign report       = report_q;
	assign filling      = filling_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for battery_capacity_estimator: a gauge predictor runs on
// every accepted poll beat and each result beat is compared against its expectation.
// Depends on bce_pkg and the battery_capacity_estimator RTL.
module tb_top;
	import bce_pkg::*;

	localparam int WIN         = 12;
	localparam int SEGS        = 7;
	localparam int DRAIN_WAIT  = 2 * WIN + 16;
	localparam int CYCLE_LIMIT = 600000;

	localparam int unsigned DIS_MV  [8] = '{3600, 3648, 3680, 3744, 3855, 3916, 4060, 4200};
	localparam int unsigned DIS_PCT [8] = '{0, 10, 20, 40, 60, 80, 90, 100};
	localparam int unsigned CHG_MV  [8] = '{3690, 3744, 3776, 3828, 3936, 4060, 4140, 4230};
	localparam int unsigned CHG_PCT [8] = '{0, 10, 20, 40, 60, 80, 90, 100};

	typedef struct packed {
		logic [CAP_W-1:0] capacity;
		logic             report;
		logic             filling;
	} gauge_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              poll_valid = 1'b0;
	logic              poll_stall;
	logic [VOLT_W-1:0] voltage_mv = '0;
	logic [ST_W-1:0]   charge_state = ST_DIS;
	logic              restart = 1'b0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [CAP_W-1:0]  capacity;
	logic              report;
	logic              filling;

	battery_capacity_estimator #(.WINDOW(WIN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.poll_valid(poll_valid),
		.poll_stall(poll_stall),
		.voltage_mv(voltage_mv),
		.charge_state(charge_state),
		.restart(restart),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.capacity(capacity),
		.report(report),
		.filling(filling)
	);

	always #2 clk = ~clk;

	// gauge predictor state
	int unsigned       win_cap   [WIN];
	int unsigned       win_volt  [WIN];
	int unsigned       win_order [WIN];
	int unsigned       next_slot;
	int unsigned       fill_cnt;
	logic [ST_W-1:0]   last_state;
	int unsigned       shown_cap;

	gauge_t pending_q [$];
	gauge_t seen;
	int     errors = 0;
	int     polls_sent = 0;
	int     results_checked = 0;
	int     reports_seen = 0;
	int     cycles = 0;
	bit     tx_idle_on = 1'b1;
	bit     rx_idle_on = 1'b1;
	int     stall_left = 0;
	bit     stall_now = 1'b0;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned curve_pct(logic [ST_W-1:0] st, logic [VOLT_W-1:0] v);
		int unsigned       mv [8];
		int unsigned       pct [8];
		int unsigned       k;
		longint unsigned   acc;
		for (int i = 0; i < 8; i++) begin
			mv[i]  = (st != ST_DIS) ? CHG_MV[i] : DIS_MV[i];
			pct[i] = (st != ST_DIS) ? CHG_PCT[i] : DIS_PCT[i];
		end
		if (st == ST_FULL)
			return 100;
		if (v <= mv[0])
			return 0;
		for (int i = 0; i < SEGS; i++) begin
			if (v <= mv[i+1]) begin
				k = ((pct[i+1] - pct[i]) * 65536) / (mv[i+1] - mv[i]);
				acc = longint'(int'(v) - int'(mv[i])) * k + longint'(pct[i]) * 65536;
				acc = acc >> 16;
				return (acc > 100) ? 100 : int'(acc);
			end
		end
		return 100;
	endfunction

	function automatic int unsigned window_mean(bit charging);
		int unsigned skip;
		int unsigned cnt;
		int unsigned sum;
		skip = charging ? 2 : 1;
		cnt  = charging ? WIN - 4 : WIN - (WIN / 2 + 1);
		sum  = 0;
		for (int i = 0; i < cnt; i++)
			sum += win_cap[win_order[(skip + i) % WIN]];
		return (sum + cnt / 2) / cnt;
	endfunction

	function automatic void place_sample(int unsigned slot, int unsigned cap,
			int unsigned v);
		int unsigned rest [WIN];
		int unsigned n;
		int unsigned p;
		n = 0;
		for (int i = 0; i < WIN; i++)
			if (win_order[i] != slot) begin
				rest[n] = win_order[i];
				n++;
			end
		win_cap[slot]  = cap;
		win_volt[slot] = v;
		p = 0;
		while (p < n && (win_cap[rest[p]] > cap ||
				(win_cap[rest[p]] == cap && win_volt[rest[p]] > v)))
			p++;
		for (int i = 0; i < p; i++)
			win_order[i] = rest[i];
		win_order[p] = slot;
		for (int i = p; i < n && i + 1 < WIN; i++)
			win_order[i+1] = rest[i];
	endfunction

	function automatic gauge_t predict_poll(logic [VOLT_W-1:0] v, logic [ST_W-1:0] st_in,
			logic rs);
		logic [ST_W-1:0] st;
		int unsigned     upd;
		int unsigned     cap;
		int unsigned     avg;
		gauge_t          g;
		st  = (st_in == ST_ALT) ? ST_FULL : st_in;
		upd = 0;
		if (rs)
			fill_cnt = 1;
		if (st != last_state) begin
			last_state = st;
			upd = 1;
			if (fill_cnt != 0)
				fill_cnt = 1;
		end else begin
			cap = curve_pct(st, v);
			if (fill_cnt == 0 && ((st == ST_DIS) == (cap > shown_cap)))
				cap = shown_cap;
			place_sample(next_slot % WIN, cap, v);
			next_slot = (next_slot + 1 >= WIN) ? 0 : next_slot + 1;
			if (fill_cnt != 0) begin
				if (fill_cnt >= WIN) begin
					fill_cnt = 0;
					upd = 2;
				end else begin
					fill_cnt++;
				end
			end
			if (fill_cnt == 0 && cap != shown_cap) begin
				avg = window_mean(st != ST_DIS);
				if (avg == 100 && st == ST_CHG)
					avg = 99;
				if (avg != shown_cap) begin
					if (upd != 2) begin
						if ((st != ST_DIS) == (avg > shown_cap)) begin
							if (st != ST_DIS)
								shown_cap++;
							else
								shown_cap--;
							upd = 2;
						end
					end else begin
						if (st != ST_DIS && avg >= CAP_SNAP && avg < 100)
							avg = 100;
						shown_cap = avg;
					end
				end
			end
		end
		g.capacity = shown_cap[CAP_W-1:0];
		g.report   = (upd != 0);
		g.filling  = (fill_cnt != 0);
		return g;
	endfunction

	task automatic send_poll(input logic [VOLT_W-1:0] v, input logic [ST_W-1:0] st,
			input logic rs);
		int gap;
		gap = tx_idle_on ? idle_len() : 0;
		if (gap > 0) begin
			poll_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		poll_valid   <= 1'b1;
		voltage_mv   <= v;
		charge_state <= st;
		restart      <= rs;
		@(posedge clk);
		while (poll_stall)
			@(posedge clk);
		pending_q.push_back(predict_poll(v, st, rs));
		polls_sent++;
	endtask

	task automatic drain_results();
		poll_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_fill_extremes();
		logic [VOLT_W-1:0] mv [12];
		mv = '{13'd0, 13'd3600, 13'd3601, 13'd3648, 13'd3700, 13'd3855,
			13'd4060, 13'd4199, 13'd4200, 13'd4201, 13'd8191, 13'd3900};
		foreach (mv[i])
			send_poll(mv[i], ST_DIS, 1'b0);
		send_poll(13'd3700, ST_DIS, 1'b0);
		send_poll(13'd3610, ST_DIS, 1'b0);
	endtask

	task automatic test_state_changes();
		send_poll(13'd3800, ST_CHG, 1'b0);
		send_poll(13'd4235, ST_CHG, 1'b0);
		send_poll(13'd3690, ST_CHG, 1'b1);
		send_poll(13'd5461, ST_ALT, 1'b0);
		send_poll(13'd2730, ST_FULL, 1'b0);
		send_poll(13'd4100, ST_ALT, 1'b1);
		send_poll(13'd4000, ST_DIS, 1'b0);
		send_poll(13'd4000, ST_DIS, 1'b1);
		drain_results();
	endtask

	task automatic test_random_sessions(input int n_polls);
		int              mv;
		int              run;
		int              since_drain;
		logic [ST_W-1:0] st;
		since_drain = 0;
		while (n_polls > 0) begin
			st  = ST_W'($urandom_range(0, 3));
			run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : $urandom_range(13, 40);
			mv  = $urandom_range(3550, 4300);
			for (int i = 0; i < run && n_polls > 0; i++) begin
				mv += (st == ST_DIS) ? -int'($urandom_range(0, 12)) : int'($urandom_range(0, 12));
				mv += int'($urandom_range(0, 10)) - 5;
				mv = (mv < 3400) ? 3400 : (mv > 4400) ? 4400 : mv;
				if ($urandom_range(0, 99) < 8)
					send_poll(VOLT_W'($urandom_range(0, 8191)), ST_W'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)));
				else
					send_poll(VOLT_W'(mv), st, ($urandom_range(0, 99) < 3));
				n_polls--;
				since_drain++;
				if (since_drain >= 150) begin
					drain_results();
					since_drain = 0;
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			results_checked++;
			if (report)
				reports_seen++;
			if (pending_q.size() == 0) begin
				$error("result beat with nothing pending: capacity %0d", capacity);
				errors++;
			end else begin
				seen = pending_q.pop_front();
				if (capacity !== seen.capacity) begin
					$error("capacity: expected %0d, got %0d", seen.capacity, capacity);
					errors++;
				end
				if (report !== seen.report) begin
					$error("report: expected %0d, got %0d", seen.report, report);
					errors++;
				end
				if (filling !== seen.filling) begin
					$error("filling: expected %0d, got %0d", seen.filling, filling);
					errors++;
				end
			end
		end
		if (stall_left == 0) begin
			stall_now = rx_idle_on && ($urandom_range(0, 3) == 0);
			stall_left = stall_now ? idle_len() : $urandom_range(1, 6);
		end else begin
			stall_left--;
		end
		result_stall <= stall_now;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[battery_capacity_estimator] ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < WIN; i++) begin
			win_cap[i]   = 0;
			win_volt[i]  = 0;
			win_order[i] = i;
		end
		next_slot  = 0;
		fill_cnt   = 1;
		last_state = ST_DIS;
		shown_cap  = 100;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_extremes();
		test_state_changes();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		test_random_sessions(100);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		test_random_sessions(700);
		drain_results();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Sent %0d poll beats across fill, state-change and random charge sessions;",
			polls_sent);
		$display("checked %0d result beats, %0d of them with report raised.",
			results_checked, reports_seen);
		if (errors == 0 && pending_q.size() == 0)
			$display("[battery_capacity_estimator] OK");
		else
			$display("[battery_capacity_estimator] ERROR");
		$finish;
	end

endmodule
